// ===== rtl/mm4_pkg.sv =====
// Shared types and fixed constants for the matrix multiply block.
package mm4_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] a_value;
        logic signed [DATA_WIDTH-1:0] b_value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] c_value;
        logic                         last;
    } t_out_word;

    // Tag that follows each multiply-accumulate step down the pipe.
    typedef struct packed {
        logic valid;
        logic first;
        logic lastk;
        logic tail;
    } t_mac_tag;

    typedef enum logic [1:0] {
        S_LOAD,
        S_RUN,
        S_DRAIN
    } t_state;

endpackage

// ===== rtl/matrix4x4_multiply.sv =====
// Top level: fixed-point DIM x DIM matrix product with one shared multiply-accumulate unit.
//
// Input: a word is taken at a clock edge with start high and busy low. Each word carries
// one element of A and the element of B at the same row-major position. The first
// DIM*DIM - 1 words only load the two element memories.
// The DIM*DIM-th word starts the product: busy rises and one multiply-accumulate is
// issued per cycle, row by row and column by column, DIM steps per element of C, so
// DIM*DIM*DIM steps in all (64 at DIM = 4). The pipe is read memory, multiply,
// accumulate, saturate; each element of C leaves after its last product is accumulated.
// Results: o_strobe is high for exactly one cycle with each element of C in row-major
// order; o_result.last marks the final one. The receiver cannot stall the block.
// busy falls in the cycle that shows the final element.
// Each element is the full-width sum of DIM products, shifted right by FRAC_BITS
// (floor) and saturated to the signed data width.
// Reset (synchronous, active low) clears the load count, the sequencer and the strobe;
// the element memories are not cleared.
module matrix4x4_multiply #(
    parameter int DIM = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mm4_pkg::t_in_word  i_data,
    output logic               o_strobe,
    output mm4_pkg::t_out_word o_result
);
    import mm4_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int CW    = $clog2(CELLS);
    localparam int IW    = $clog2(DIM);
    localparam int DW    = DATA_WIDTH;
    localparam int PW    = 2 * DW;
    localparam int ACC_W = PW + IW;

    logic signed [DW-1:0] r_mem_a [CELLS];
    logic signed [DW-1:0] r_mem_b [CELLS];

    t_state        r_state, n_state;
    logic [CW-1:0] r_load_cnt, n_load_cnt;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_col, n_col;
    logic [IW-1:0] r_k, n_k;

    logic          accept;
    logic          issue;
    logic          issue_last;
    logic [CW-1:0] addr_a;
    logic [CW-1:0] addr_b;
    t_mac_tag      issue_tag;

    t_mac_tag             r_tag1, r_tag2;
    logic signed [DW-1:0] r_a_rd, r_b_rd;
    logic signed [PW-1:0] r_prod;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] prod_ext;
    logic                    r_done, r_done_tail;

    logic signed [ACC_W-1:0] shifted;
    logic [ACC_W-DW:0]       upper;
    logic                    in_range;
    logic signed [DW-1:0]    sat_value;

    assign accept = start && !busy;
    assign busy   = (r_state != S_LOAD);

    assign addr_a = CW'(int'(r_row) * DIM + int'(r_k));
    assign addr_b = CW'(int'(r_k) * DIM + int'(r_col));

    assign issue_last = (r_k == IW'(DIM - 1)) && (r_col == IW'(DIM - 1))
                        && (r_row == IW'(DIM - 1));

    always_comb begin
        issue_tag.valid = issue;
        issue_tag.first = (r_k == '0);
        issue_tag.lastk = (r_k == IW'(DIM - 1));
        issue_tag.tail  = issue_last;
    end

    // Sequencer: load, issue DIM^3 steps, then drain the pipe.
    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        issue      = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_load_cnt == CW'(CELLS - 1)) begin
                        n_load_cnt = '0;
                        n_row      = '0;
                        n_col      = '0;
                        n_k        = '0;
                        n_state    = S_RUN;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            S_RUN: begin
                issue = 1'b1;
                if (r_k == IW'(DIM - 1)) begin
                    n_k = '0;
                    if (r_col == IW'(DIM - 1)) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
                if (issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // leave once the final element goes to the output register
                if (r_done && r_done_tail) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            r_k        <= n_k;
        end
    end

    // Element memories: written while loading, read once per issue.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_a[r_load_cnt] <= i_data.a_value;
            r_mem_b[r_load_cnt] <= i_data.b_value;
        end
        r_a_rd <= r_mem_a[addr_a];
        r_b_rd <= r_mem_b[addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_a_rd * r_b_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= issue_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign prod_ext = {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};
    assign acc_base = r_tag2.first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (r_tag2.valid) begin
            r_acc <= acc_base + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_done_tail <= 1'b0;
        end else begin
            r_done      <= r_tag2.valid && r_tag2.lastk;
            r_done_tail <= r_tag2.valid && r_tag2.tail;
        end
    end

    // Floor the fraction off, then clamp to the signed data range.
    assign shifted   = r_acc >>> FRAC_BITS;
    assign upper     = shifted[ACC_W-1:DW-1];
    assign in_range  = (&upper) || !(|upper);
    assign sat_value = shifted[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_done) begin
            o_result.c_value <= in_range ? shifted[DW-1:0] : sat_value;
            o_result.last    <= r_done_tail;
        end
    end

endmodule

// ===== tb/sv/matrix4x4_multiply_tb.sv =====
// Testbench for the 4x4 fixed-point matrix multiply: directed and random loads checked word by word.
module matrix4x4_multiply_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mm4_pkg::*;

    localparam int DIM       = 4;
    localparam int CELLS     = DIM * DIM;
    localparam int RAND_MATS = 12;
    localparam int MAX_SHOWN = 10;

    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

    localparam logic [DATA_WIDTH-1:0] MAX_V = 32'h7FFF_FFFF;
    localparam logic [DATA_WIDTH-1:0] MIN_V = 32'h8000_0000;

    // one directed word: both elements, plus the product element when it is obvious
    typedef struct packed {
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic                  known;
        logic [DATA_WIDTH-1:0] c;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_word  i_data  = '0;
    logic      o_strobe;
    t_out_word o_result;

    logic signed [DATA_WIDTH-1:0] left_mat  [CELLS];
    logic signed [DATA_WIDTH-1:0] right_mat [CELLS];
    int                           load_pos   = 0;
    t_out_word                    product_q[$];
    int                           fail_count = 0;
    int                           idle_pct   = 37;
    logic                         typed_known [CELLS];
    logic        [DATA_WIDTH-1:0] typed_c     [CELLS];

    // A rows: all max, all min, {1 lsb, 1.0, 0, 0}, {-1 lsb, 0, 0, 0}.
    // B row 0 is all max and B is non-negative, so rows 0, 1 and 3 of C are plain.
    t_dir_row dir_rows [CELLS] = '{
        '{MAX_V,         MAX_V,         1'b1, MAX_V},
        '{MAX_V,         MAX_V,         1'b1, MAX_V},
        '{MAX_V,         MAX_V,         1'b1, MAX_V},
        '{MAX_V,         MAX_V,         1'b1, MAX_V},
        '{MIN_V,         32'h0001_0000, 1'b1, MIN_V},
        '{MIN_V,         32'h0002_0000, 1'b1, MIN_V},
        '{MIN_V,         32'h0000_8000, 1'b1, MIN_V},
        '{MIN_V,         32'h0000_0001, 1'b1, MIN_V},
        '{32'h0000_0001, MAX_V,         1'b0, 32'h0},
        '{32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h1234_5678, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_8000},
        '{32'h0000_0000, MAX_V,         1'b1, 32'hFFFF_8000},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_8000},
        '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'hFFFF_8000}
    };

    matrix4x4_multiply #(
        .DIM(DIM)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Row of A dot column of B, floored by the fraction bits, then clamped.
    function automatic logic [DATA_WIDTH-1:0] fixed_dot(input int row, input int col);
        logic signed [127:0] acc;
        logic signed [127:0] shifted;
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
            acc = acc + left_mat[row*DIM + k] * right_mat[k*DIM + col];
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > SAT_HI) begin
            return MAX_V;
        end else if (shifted < SAT_LO) begin
            return MIN_V;
        end
        return shifted[DATA_WIDTH-1:0];
    endfunction

    // Store the accepted word; on the final cell queue the whole product.
    function automatic void take_word(input t_in_word w);
        t_out_word res;
        left_mat[load_pos]  = w.a_value;
        right_mat[load_pos] = w.b_value;
        if (load_pos < CELLS - 1) begin
            load_pos++;
            return;
        end
        load_pos = 0;
        for (int n = 0; n < CELLS; n++) begin
            res.c_value = typed_known[n] ? typed_c[n] : fixed_dot(n / DIM, n % DIM);
            res.last    = (n == CELLS - 1);
            product_q.push_back(res);
        end
    endfunction

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        // hold the word until the block is free
        while (busy) @(posedge i_clk);
        take_word(w);
    endtask

    // Mostly modest Q16.16 values so that sums rarely clamp, with extremes mixed in.
    function automatic logic [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0:       return MAX_V;
            1:       return MIN_V;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out_word exp_w;
        if (i_rst_n && o_strobe) begin
            if (product_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected word c=%h last=%b",
                                        o_result.c_value, o_result.last));
            end else begin
                exp_w = product_q.pop_front();
                if (o_result.c_value !== exp_w.c_value) begin
                    flag_mismatch($sformatf("c_value exp %h got %h",
                                            exp_w.c_value, o_result.c_value));
                end
                if (o_result.last !== exp_w.last) begin
                    flag_mismatch($sformatf("last exp %b got %b",
                                            exp_w.last, o_result.last));
                end
            end
        end
    end

    initial begin : stimulus
        t_in_word w;
        int       guard;
        for (int n = 0; n < CELLS; n++) begin
            typed_known[n] = 1'b0;
            typed_c[n]     = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < CELLS; n++) begin
            typed_known[n] = dir_rows[n].known;
            typed_c[n]     = dir_rows[n].c;
            w.a_value      = dir_rows[n].a;
            w.b_value      = dir_rows[n].b;
            send_word(w);
        end
        for (int n = 0; n < CELLS; n++) begin
            typed_known[n] = 1'b0;
        end

        for (int m = 0; m < RAND_MATS; m++) begin
            // a run of matrices sent back to back
            idle_pct = (m >= 4 && m < 7) ? 0 : 37;
            for (int n = 0; n < CELLS; n++) begin
                w.a_value = pick_value();
                w.b_value = pick_value();
                send_word(w);
            end
        end
        start <= 1'b0;

        guard = 0;
        while (product_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DIM + 16) @(posedge i_clk);

        if (fail_count == 0 && product_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
